// ===== hdl/sapm_pkg.sv =====
// ----------------------------------------------------------------------------
// Skeleton pose and measure package
// Shared widths, register indexes, reset values and the sequencer's
// state and operation codes.
// ----------------------------------------------------------------------------
package sapm_pkg;

	// field and datapath widths
	localparam int FIELD_W    = 16;
	localparam int DIFF_W     = 17;
	localparam int ACC_W      = 42;
	localparam int RAD_W      = 34;
	localparam int ROOT_W     = 17;
	localparam int REM_W      = 19;
	localparam int NUM_W      = 19;
	localparam int DREM_W     = 3;
	localparam int CNT_W      = 5;
	localparam int WIDTH_W    = 16;
	localparam int HEIGHT_W   = 12;
	localparam int HLIM_W     = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_W      = 16;
	localparam int IN_W       = 10 * FIELD_W;
	localparam int OUT_W      = 32;
	localparam int SHIFT_CM   = 27;
	localparam int D_SHIFT    = 15;

	// step counts of the serial units
	localparam int MUL_STEPS  = DIFF_W;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int DIV_STEPS  = NUM_W;

	// constants of the arithmetic
	localparam logic [DIFF_W-1:0]  SCALE_CM   = 17'd100;
	localparam logic [ACC_W-1:0]   ROUND_CM   = ACC_W'(64'd1 << (SHIFT_CM - 1));
	localparam logic [DREM_W:0]    DIVISOR    = 4'd5;
	localparam logic [NUM_W-1:0]   ROUND_DIV  = 19'd2;
	localparam logic signed [SHIFT_CM-12:0] HEIGHT_MAX = 16'sd2047;
	localparam logic signed [SHIFT_CM-12:0] HEIGHT_MIN = -16'sd2048;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_A  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_B  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_C  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_D  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HAND_LIM = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_YAW_LIM  = 3'd5;

	// reset values
	localparam logic [FIELD_W-1:0]  PLANE_A_RST  = 16'd1406;
	localparam logic [FIELD_W-1:0]  PLANE_B_RST  = 16'd15879;
	localparam logic [FIELD_W-1:0]  PLANE_C_RST  = 16'hF136;
	localparam logic [FIELD_W-1:0]  PLANE_D_RST  = 16'd6226;
	localparam logic [HLIM_W-1:0]   HAND_LIM_RST = 15'd2048;
	localparam logic [FIELD_W-1:0]  YAW_LIM_RST  = 16'd11556;
	localparam logic [WIDTH_W-1:0]  WIDTH_RST    = 16'd1372;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST   = 12'd130;

	// sequencer states
	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_CHECK    = 8'b0000_0010,
		S_MUL      = 8'b0000_0100,
		S_DISPATCH = 8'b0000_1000,
		S_SQRT     = 8'b0001_0000,
		S_DIVINIT  = 8'b0010_0000,
		S_DIV      = 8'b0100_0000,
		S_FINISH   = 8'b1000_0000
	} state_t;

	// products run through the shared shift-add multiplier, in this order
	typedef enum logic [2:0] {
		OP_YAW = 3'd0,
		OP_DX  = 3'd1,
		OP_DY  = 3'd2,
		OP_DZ  = 3'd3,
		OP_A   = 3'd4,
		OP_B   = 3'd5,
		OP_C   = 3'd6,
		OP_H   = 3'd7
	} op_t;

endpackage

// ===== hdl/skeleton_pose_and_measure.sv =====
// ----------------------------------------------------------------------------
// Skeleton pose and measure
// Pose check on one body frame, then smoothed shoulder width and shoulder
// height above the floor plane, with bit-serial arithmetic.
// ----------------------------------------------------------------------------
// One frame in, one result out. A frame that fails the shoulder/hand tests
// or the yaw test finishes early; a frame in pose runs eight products
// through one shift-add multiplier at one multiplier bit per cycle, a
// 17-step square root and a 19-step divide by five. The input is taken
// only while the sequencer is idle; a finished result waits in the output
// register, and the next frame is accepted while it waits.
module skeleton_pose_and_measure (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration writes
	input  logic                              cfg_we,
	input  logic [sapm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sapm_pkg::CFG_W-1:0]        cfg_data,
	// frame input
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// lsx, lsy, lsz, rsx, rsy, rsz, lhx, lhy, rhx, rhy (16 bits each)
	input  logic [sapm_pkg::IN_W-1:0]         s_axis_tdata,
	// result output
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// in_pose[0], width_out[16:1], height_cm[28:17], zero[31:29]
	output logic [sapm_pkg::OUT_W-1:0]        m_axis_tdata
);
	import sapm_pkg::*;

	state_t state_q;
	op_t    sel_q;

	// configuration registers
	logic [FIELD_W-1:0] plane_a_q, plane_b_q, plane_c_q, plane_d_q, yaw_lim_q;
	logic [HLIM_W-1:0]  hand_lim_q;

	// captured frame
	logic [FIELD_W-1:0] lsx_q, lsy_q, lsz_q, rsx_q, rsy_q, rsz_q;
	logic [FIELD_W-1:0] lhx_q, lhy_q, rhx_q, rhy_q;

	// measurement state
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic                pose_q;

	// serial units
	logic [ACC_W-1:0]  acc_q, mc_q;
	logic [DIFF_W-1:0] mp_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  num_q;
	logic [DREM_W-1:0] drem_q;

	// output register
	logic                m_valid_q;
	logic [OUT_W-1:0]    m_data_q;

	// frame differences and sums
	logic signed [DIFF_W-1:0] dx, dy, dz, sx, sy, sz, hdl, hdr;
	logic [DIFF_W-1:0]        habs_l, habs_r, dz_abs;
	logic                     coarse_ok, yaw_ok;

	assign dx  = $signed({rsx_q[FIELD_W-1], rsx_q}) - $signed({lsx_q[FIELD_W-1], lsx_q});
	assign dy  = $signed({rsy_q[FIELD_W-1], rsy_q}) - $signed({lsy_q[FIELD_W-1], lsy_q});
	assign dz  = $signed({rsz_q[FIELD_W-1], rsz_q}) - $signed({lsz_q[FIELD_W-1], lsz_q});
	assign sx  = $signed({rsx_q[FIELD_W-1], rsx_q}) + $signed({lsx_q[FIELD_W-1], lsx_q});
	assign sy  = $signed({rsy_q[FIELD_W-1], rsy_q}) + $signed({lsy_q[FIELD_W-1], lsy_q});
	assign sz  = $signed({rsz_q[FIELD_W-1], rsz_q}) + $signed({lsz_q[FIELD_W-1], lsz_q});
	assign hdl = $signed({lhx_q[FIELD_W-1], lhx_q}) - $signed({lsx_q[FIELD_W-1], lsx_q});
	assign hdr = $signed({rhx_q[FIELD_W-1], rhx_q}) - $signed({rsx_q[FIELD_W-1], rsx_q});

	assign habs_l = hdl[DIFF_W-1] ? DIFF_W'(-hdl) : DIFF_W'(hdl);
	assign habs_r = hdr[DIFF_W-1] ? DIFF_W'(-hdr) : DIFF_W'(hdr);
	assign dz_abs = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);

	// shoulders above hands, hands near shoulders, shoulder line toward +x
	assign coarse_ok = ($signed(lsy_q) > $signed(lhy_q)) && ($signed(rsy_q) > $signed(rhy_q))
		&& (habs_l < {2'b00, hand_lim_q}) && (habs_r < {2'b00, hand_lim_q})
		&& !dx[DIFF_W-1] && (dx != '0);

	// acc holds tan_limit * dx here; compare against |dz| scaled by 2^16
	assign yaw_ok = acc_q[RAD_W-1:0] > {1'b0, dz_abs, {(RAD_W-DIFF_W-1){1'b0}}};

	// choose the next product to start
	op_t              start_sel;
	logic             start_mul;
	logic [ACC_W-1:0] op_mc;
	logic [DIFF_W-1:0] op_mp;
	logic [ACC_W-1:0] d_term;

	assign d_term = ACC_W'($signed({plane_d_q, {D_SHIFT{1'b0}}}));

	always_comb begin
		start_mul = 1'b0;
		start_sel = OP_YAW;
		unique case (state_q)
			S_CHECK: begin
				start_mul = coarse_ok;
				start_sel = OP_YAW;
			end
			S_DIV: begin
				start_mul = (cnt_q == CNT_W'(DIV_STEPS - 1));
				start_sel = OP_A;
			end
			S_DISPATCH: begin
				unique case (sel_q)
					OP_YAW: begin
						start_mul = yaw_ok;
						start_sel = OP_DX;
					end
					OP_DX: begin
						start_mul = 1'b1;
						start_sel = OP_DY;
					end
					OP_DY: begin
						start_mul = 1'b1;
						start_sel = OP_DZ;
					end
					OP_A: begin
						start_mul = 1'b1;
						start_sel = OP_B;
					end
					OP_B: begin
						start_mul = 1'b1;
						start_sel = OP_C;
					end
					OP_C: begin
						start_mul = 1'b1;
						start_sel = OP_H;
					end
					default: begin
						start_mul = 1'b0;
						start_sel = OP_YAW;
					end
				endcase
			end
			default: begin
				start_mul = 1'b0;
				start_sel = OP_YAW;
			end
		endcase
	end

	// operand mux for the shared multiplier
	always_comb begin
		unique case (start_sel)
			OP_YAW: begin
				op_mc = ACC_W'(dx);
				op_mp = {1'b0, yaw_lim_q};
			end
			OP_DX: begin
				op_mc = ACC_W'(dx);
				op_mp = dx;
			end
			OP_DY: begin
				op_mc = ACC_W'(dy);
				op_mp = dy;
			end
			OP_DZ: begin
				op_mc = ACC_W'(dz);
				op_mp = dz;
			end
			OP_A: begin
				op_mc = ACC_W'($signed(plane_a_q));
				op_mp = sx;
			end
			OP_B: begin
				op_mc = ACC_W'($signed(plane_b_q));
				op_mp = sy;
			end
			OP_C: begin
				op_mc = ACC_W'($signed(plane_c_q));
				op_mp = sz;
			end
			OP_H: begin
				op_mc = acc_q + d_term;
				op_mp = SCALE_CM;
			end
			default: begin
				op_mc = '0;
				op_mp = '0;
			end
		endcase
	end

	// one multiplier bit per cycle; the top bit carries negative weight
	logic [ACC_W-1:0] addend, acc_step;

	assign addend   = (cnt_q == CNT_W'(MUL_STEPS - 1)) ? ACC_W'(-mc_q) : mc_q;
	assign acc_step = mp_q[0] ? acc_q + addend : acc_q;

	// one root bit per cycle
	logic [REM_W+1:0] rem_sh, trial;
	logic             sq_ge;

	assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = {{(REM_W+2-ROOT_W-2){1'b0}}, root_q, 2'b01};
	assign sq_ge  = rem_sh >= trial;

	// one quotient bit per cycle of the divide by five
	logic [DREM_W:0]    drem_sh;
	logic               dv_ge;
	logic [NUM_W-1:0]   quot;
	logic [WIDTH_W-1:0] width_sat;

	assign drem_sh   = {drem_q, num_q[NUM_W-1]};
	assign dv_ge     = drem_sh >= DIVISOR;
	assign quot      = {num_q[NUM_W-2:0], dv_ge};
	assign width_sat = (quot[NUM_W-1:WIDTH_W] != '0) ? '1 : quot[WIDTH_W-1:0];

	// height: round 100*H to centimetres, then saturate
	logic [ACC_W-1:0]               h_round;
	logic signed [ACC_W-SHIFT_CM-1:0] h_cm;
	logic [HEIGHT_W-1:0]            height_new;

	assign h_round = acc_q + ROUND_CM;
	assign h_cm    = $signed(h_round[ACC_W-1:SHIFT_CM]);

	always_comb begin
		priority if (h_cm > HEIGHT_MAX) begin
			height_new = HEIGHT_MAX[HEIGHT_W-1:0];
		end else if (h_cm < HEIGHT_MIN) begin
			height_new = HEIGHT_MIN[HEIGHT_W-1:0];
		end else begin
			height_new = h_cm[HEIGHT_W-1:0];
		end
	end

	logic out_free;
	logic [HEIGHT_W-1:0] height_out;

	assign out_free      = !m_valid_q || m_axis_tready;
	assign height_out    = pose_q ? height_new : height_q;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_a_q  <= PLANE_A_RST;
			plane_b_q  <= PLANE_B_RST;
			plane_c_q  <= PLANE_C_RST;
			plane_d_q  <= PLANE_D_RST;
			hand_lim_q <= HAND_LIM_RST;
			yaw_lim_q  <= YAW_LIM_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PLANE_A:  plane_a_q  <= cfg_data;
				REG_PLANE_B:  plane_b_q  <= cfg_data;
				REG_PLANE_C:  plane_c_q  <= cfg_data;
				REG_PLANE_D:  plane_d_q  <= cfg_data;
				REG_HAND_LIM: hand_lim_q <= cfg_data[HLIM_W-1:0];
				REG_YAW_LIM:  yaw_lim_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture the frame on each input transaction
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			lsx_q <= s_axis_tdata[0*FIELD_W +: FIELD_W];
			lsy_q <= s_axis_tdata[1*FIELD_W +: FIELD_W];
			lsz_q <= s_axis_tdata[2*FIELD_W +: FIELD_W];
			rsx_q <= s_axis_tdata[3*FIELD_W +: FIELD_W];
			rsy_q <= s_axis_tdata[4*FIELD_W +: FIELD_W];
			rsz_q <= s_axis_tdata[5*FIELD_W +: FIELD_W];
			lhx_q <= s_axis_tdata[6*FIELD_W +: FIELD_W];
			lhy_q <= s_axis_tdata[7*FIELD_W +: FIELD_W];
			rhx_q <= s_axis_tdata[8*FIELD_W +: FIELD_W];
			rhy_q <= s_axis_tdata[9*FIELD_W +: FIELD_W];
		end
	end

	// serial datapath registers
	always_ff @(posedge clk) begin
		if (start_mul) begin
			mc_q  <= op_mc;
			mp_q  <= op_mp;
			cnt_q <= '0;
			// squares and plane terms accumulate; other products start clean
			if (start_sel == OP_YAW || start_sel == OP_DX || start_sel == OP_A
				|| start_sel == OP_H) begin
				acc_q <= '0;
			end
		end else begin
			unique case (state_q)
				S_MUL: begin
					acc_q <= acc_step;
					mc_q  <= {mc_q[ACC_W-2:0], 1'b0};
					mp_q  <= {mp_q[DIFF_W-1], mp_q[DIFF_W-1:1]};
					cnt_q <= cnt_q + 1'b1;
				end
				S_DISPATCH: begin
					// sum of squares goes to the root unit
					rad_q  <= acc_q[RAD_W-1:0];
					root_q <= '0;
					rem_q  <= '0;
					cnt_q  <= '0;
				end
				S_SQRT: begin
					rad_q <= {rad_q[RAD_W-3:0], 2'b00};
					if (sq_ge) begin
						rem_q  <= REM_W'(rem_sh - trial);
						root_q <= {root_q[ROOT_W-2:0], 1'b1};
					end else begin
						rem_q  <= REM_W'(rem_sh);
						root_q <= {root_q[ROOT_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
				end
				S_DIVINIT: begin
					num_q  <= {1'b0, width_q, 2'b00} + NUM_W'(root_q) + ROUND_DIV;
					drem_q <= '0;
					cnt_q  <= '0;
				end
				S_DIV: begin
					drem_q <= dv_ge ? DREM_W'(drem_sh - DIVISOR) : drem_sh[DREM_W-1:0];
					num_q  <= quot;
					cnt_q  <= cnt_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free) begin
			m_data_q <= {{(OUT_W-1-WIDTH_W-HEIGHT_W){1'b0}}, height_out, width_q, pose_q};
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sel_q     <= OP_YAW;
			pose_q    <= 1'b0;
			width_q   <= WIDTH_RST;
			height_q  <= HEIGHT_RST;
			m_valid_q <= 1'b0;
		end else begin
			// raise valid with a new result, drop it once taken
			if (state_q == S_FINISH && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (start_mul) begin
				sel_q   <= start_sel;
				state_q <= S_MUL;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					pose_q <= coarse_ok;
					if (!coarse_ok) begin
						state_q <= S_FINISH;
					end
				end
				S_MUL: begin
					if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					priority if (sel_q == OP_YAW) begin
						pose_q <= yaw_ok;
						if (!yaw_ok) begin
							state_q <= S_FINISH;
						end
					end else if (sel_q == OP_DZ) begin
						state_q <= S_SQRT;
					end else if (sel_q == OP_H) begin
						state_q <= S_FINISH;
					end else begin
						// next product already started
					end
				end
				S_SQRT: begin
					if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
						state_q <= S_DIVINIT;
					end
				end
				S_DIVINIT: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						width_q <= width_sat;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						height_q <= height_out;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== tb/sv/tb_skeleton_pose_and_measure.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Skeleton pose and measure testbench
// Drives body frames into the block at random pacing and compares every
// result with an in-bench prediction of the pose flag, the smoothed shoulder
// width and the held shoulder height. Runs through several register
// settings, from reset values to the extremes, mostly with both sides stalling.
// ----------------------------------------------------------------------------
module tb_skeleton_pose_and_measure;
	import sapm_pkg::*;

	localparam int NUM_PHASES  = 6;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_WAIT  = 400;
	localparam int MAX_REPORTS = 40;

	// writes to these indexes hit no register
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_0 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_1 = 3'd7;

	// one body frame, first field in the lowest bits
	typedef struct packed {
		logic signed [15:0] rh_y;
		logic signed [15:0] rh_x;
		logic signed [15:0] lh_y;
		logic signed [15:0] lh_x;
		logic signed [15:0] rs_z;
		logic signed [15:0] rs_y;
		logic signed [15:0] rs_x;
		logic signed [15:0] ls_z;
		logic signed [15:0] ls_y;
		logic signed [15:0] ls_x;
	} frame_t;

	// one result: in_pose, width_out, height_cm, then zero fill
	typedef struct packed {
		logic [2:0]  pad;
		logic [11:0] height_cm;
		logic [15:0] width_out;
		logic        in_pose;
	} pose_result_t;

	// ------------------------------------------------------------------------
	// Pose predictor and result checker
	// ------------------------------------------------------------------------
	class pose_scoreboard;
		logic [15:0]  cfg_regs[6];
		logic [15:0]  width;
		logic [11:0]  height;
		pose_result_t expected_q[$];
		int           errors;

		function new();
			cfg_regs[REG_PLANE_A]  = PLANE_A_RST;
			cfg_regs[REG_PLANE_B]  = PLANE_B_RST;
			cfg_regs[REG_PLANE_C]  = PLANE_C_RST;
			cfg_regs[REG_PLANE_D]  = PLANE_D_RST;
			cfg_regs[REG_HAND_LIM] = {1'b0, HAND_LIM_RST};
			cfg_regs[REG_YAW_LIM]  = YAW_LIM_RST;
			width  = WIDTH_RST;
			height = HEIGHT_RST;
			errors = 0;
		endfunction

		// mirror a register write; the hand limit keeps 15 bits
		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
			if (idx == REG_HAND_LIM) begin
				cfg_regs[idx] = {1'b0, data[14:0]};
			end else if (idx <= REG_YAW_LIM) begin
				cfg_regs[idx] = data;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// predict the result of one accepted frame
		function void note_frame(frame_t f);
			longint ls_x, ls_y, ls_z, rs_x, rs_y, rs_z, lh_x, lh_y, rh_x, rh_y;
			longint dx, dy, dz, adz, l_off, r_off, hand_lim, yaw_lim;
			longint sq, root, trial, w, h;
			bit pose;
			pose_result_t r;
			ls_x = f.ls_x; ls_y = f.ls_y; ls_z = f.ls_z;
			rs_x = f.rs_x; rs_y = f.rs_y; rs_z = f.rs_z;
			lh_x = f.lh_x; lh_y = f.lh_y; rh_x = f.rh_x; rh_y = f.rh_y;
			hand_lim = cfg_regs[REG_HAND_LIM];
			yaw_lim  = cfg_regs[REG_YAW_LIM];
			dx = rs_x - ls_x;
			dy = rs_y - ls_y;
			dz = rs_z - ls_z;
			adz = (dz < 0) ? -dz : dz;
			l_off = lh_x - ls_x;
			if (l_off < 0) l_off = -l_off;
			r_off = rh_x - rs_x;
			if (r_off < 0) r_off = -r_off;

			// shoulders above hands, hands near shoulders, small yaw
			pose = (ls_y > lh_y) && (rs_y > rh_y) && (l_off < hand_lim) && (r_off < hand_lim)
				&& (dx > 0) && ((adz << 16) < yaw_lim * dx);

			if (pose) begin
				// integer square root of the squared shoulder distance
				sq = dx * dx + dy * dy + dz * dz;
				root = 0;
				for (int b = 17; b >= 0; b--) begin
					trial = root + (longint'(1) << b);
					if (trial * trial <= sq) root = trial;
				end
				w = (4 * longint'(width) + root + 2) / 5;
				width = (w > 65535) ? 16'hFFFF : 16'(w);

				// plane distance of the midpoint, in units of 2^-27 m
				h = longint'($signed(cfg_regs[REG_PLANE_A])) * (ls_x + rs_x)
					+ longint'($signed(cfg_regs[REG_PLANE_B])) * (ls_y + rs_y)
					+ longint'($signed(cfg_regs[REG_PLANE_C])) * (ls_z + rs_z)
					+ longint'($signed(cfg_regs[REG_PLANE_D])) * 32768;
				h = (h * 100 + (longint'(1) << 26)) >>> 27;
				if (h < -2048) h = -2048;
				if (h > 2047) h = 2047;
				height = 12'(h);
			end

			r.pad       = '0;
			r.in_pose   = pose;
			r.width_out = width;
			r.height_cm = height;
			expected_q.push_back(r);
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= MAX_REPORTS) $display("%0t: mismatch: %s", $realtime, msg);
		endtask

		// compare one accepted result with the oldest prediction
		task check_result(pose_result_t got);
			pose_result_t want;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result %h with nothing expected", got));
				return;
			end
			want = expected_q.pop_front();
			if (got.in_pose !== want.in_pose)
				report_mismatch($sformatf("in_pose got %b expected %b",
					got.in_pose, want.in_pose));
			if (got.width_out !== want.width_out)
				report_mismatch($sformatf("width_out got %0d expected %0d",
					got.width_out, want.width_out));
			if (got.height_cm !== want.height_cm)
				report_mismatch($sformatf("height_cm got %0d expected %0d",
					$signed(got.height_cm), $signed(want.height_cm)));
			if (got.pad !== '0)
				report_mismatch($sformatf("fill bits got %b expected zero", got.pad));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [IN_W-1:0]      s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OUT_W-1:0]     m_axis_tdata;

	pose_scoreboard sb;
	int src_idle_pct;
	int sink_idle_pct;
	int phase_len[NUM_PHASES] = '{300, 300, 120, 260, 300, 300};

	skeleton_pose_and_measure u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Frame construction
	// ------------------------------------------------------------------------
	function automatic frame_t make_frame(int lsx, int lsy, int lsz, int rsx, int rsy, int rsz,
			int lhx, int lhy, int rhx, int rhy);
		frame_t f;
		f.ls_x = 16'(lsx); f.ls_y = 16'(lsy); f.ls_z = 16'(lsz);
		f.rs_x = 16'(rsx); f.rs_y = 16'(rsy); f.rs_z = 16'(rsz);
		f.lh_x = 16'(lhx); f.lh_y = 16'(lhy);
		f.rh_x = 16'(rhx); f.rh_y = 16'(rhy);
		return f;
	endfunction

	function automatic int sat16(int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// hand x strictly inside the offset limit, edges now and then
	function automatic int near_hand_x(int sx, int lim);
		int lo, hi;
		lo = (lim > 0) ? -(lim - 1) : 0;
		hi = (lim > 0) ? lim - 1 : 0;
		if (lo < -32768 - sx) lo = -32768 - sx;
		if (hi > 32767 - sx) hi = 32767 - sx;
		case ($urandom_range(0, 7))
			0: return sx + lo;
			1: return sx + hi;
			default: return sx + lo + int'($urandom_range(0, hi - lo));
		endcase
	endfunction

	// mostly posed frames with random content, some near misses, some noise
	function automatic frame_t random_frame();
		int lim, pick, dx, dz_max, dz, sgn, span;
		int lsx, lsy, lsz, rsx, rsy, rsz, lhx, lhy, rhx, rhy;
		longint yaw;
		lim  = sb.cfg_regs[REG_HAND_LIM];
		yaw  = sb.cfg_regs[REG_YAW_LIM];
		pick = $urandom_range(0, 99);
		if (pick >= 85) return frame_t'({$urandom, $urandom, $urandom, $urandom, $urandom});

		// shoulder line: mostly body-sized, sometimes as wide as the range allows
		lsx  = int'($urandom_range(0, 65534)) - 32768;
		span = 32766 - lsx;
		if (span > 2999 && $urandom_range(0, 4) != 0) span = 2999;
		dx  = 1 + int'($urandom_range(0, span));
		rsx = lsx + dx;

		// depth difference inside the yaw cone
		dz_max = (yaw * dx > 0) ? int'((yaw * dx - 1) >>> 16) : 0;
		if (dz_max > 16000) dz_max = 16000;
		if ($urandom_range(0, 7) == 0) dz = $urandom_range(0, 1) ? dz_max : -dz_max;
		else dz = int'($urandom_range(0, 2 * dz_max)) - dz_max;
		lsz = int'($urandom_range(0, 65535 - 2 * dz_max)) - 32768 + dz_max;
		rsz = lsz + dz;

		// shoulder heights, hands below them
		lsy = int'($urandom_range(0, 65534)) - 32767;
		if ($urandom_range(0, 2) == 0) rsy = int'($urandom_range(0, 65534)) - 32767;
		else rsy = sat16(lsy + int'($urandom_range(0, 400)) - 200);
		if (rsy < -32767) rsy = -32767;
		lhy = lsy - 1 - int'($urandom_range(0, lsy + 32767));
		rhy = rsy - 1 - int'($urandom_range(0, rsy + 32767));
		lhx = near_hand_x(lsx, lim);
		rhx = near_hand_x(rsx, lim);

		// break one condition of the pose
		if (pick >= 65) begin
			sgn = $urandom_range(0, 1) ? 1 : -1;
			case ($urandom_range(0, 3))
				0: begin
					if (sgn > 0) lhy = lsy + int'($urandom_range(0, 32767 - lsy));
					else rhy = rsy + int'($urandom_range(0, 32767 - rsy));
				end
				1: begin
					if ($urandom_range(0, 1)) lhx = sat16(lsx + sgn * (lim + int'($urandom_range(0, 64))));
					else rhx = sat16(rsx + sgn * (lim + int'($urandom_range(0, 64))));
				end
				2: rsz = sat16(lsz + sgn * (dz_max + 1 + int'($urandom_range(0, 64))));
				default: rsx = sat16(lsx - int'($urandom_range(0, 2000)));
			endcase
		end
		return make_frame(lsx, lsy, lsz, rsx, rsy, rsz, lhx, lhy, rhx, rhy);
	endfunction

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------
	task automatic send_frame(input frame_t f);
		// idle the input for a random stretch
		while (int'($urandom_range(0, 99)) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= f;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_frame(f);
	endtask

	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic apply_setting(input logic [15:0] a, b, c, d, hand, yaw);
		program_reg(REG_PLANE_A, a);
		program_reg(REG_PLANE_B, b);
		program_reg(REG_PLANE_C, c);
		program_reg(REG_PLANE_D, d);
		program_reg(REG_HAND_LIM, hand);
		program_reg(REG_YAW_LIM, yaw);
		// a write to an unmapped index must leave every register alone
		program_reg($urandom_range(0, 1) ? REG_SPARE_0 : REG_SPARE_1, 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Result sink: check each transaction, stall at random
	// ------------------------------------------------------------------------
	initial begin : result_sink
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_result(pose_result_t'(m_axis_tdata));
			m_axis_tready <= (int'($urandom_range(0, 99)) >= sink_idle_pct);
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: end the run when nothing moves for too long
	// ------------------------------------------------------------------------
	initial begin : watchdog
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
				stalled = 0;
			else
				stalled++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		sb = new();
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		src_idle_pct  = 32;
		sink_idle_pct = 69;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes and bit patterns
		send_frame(make_frame(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_frame(frame_t'({10{16'h8000}}));
		send_frame(frame_t'({10{16'h7FFF}}));
		send_frame(frame_t'({10{16'h5555}}));
		send_frame(frame_t'({10{16'hAAAA}}));
		// standard pose, then a hand level with its shoulder on each side
		send_frame(make_frame(-700, 5300, 8000, 700, 5350, 8050, -700, 1000, 700, 1000));
		send_frame(make_frame(-700, 5300, 8000, 700, 5350, 8050, -700, 5300, 700, 1000));
		send_frame(make_frame(-700, 5300, 8000, 700, 5350, 8050, -700, 1000, 700, 5350));
		// hand offset one below and exactly at the limit
		send_frame(make_frame(-700, 5300, 8000, 700, 5350, 8050, 1347, 1000, 700, 1000));
		send_frame(make_frame(-700, 5300, 8000, 700, 5350, 8050, 1348, 1000, 700, 1000));
		// yaw just inside and exactly on the tangent limit
		send_frame(make_frame(-8192, 5300, 0, 8192, 5300, 2888, -8192, 1000, 8192, 1000));
		send_frame(make_frame(-8192, 5300, 0, 8192, 5300, 2889, -8192, 1000, 8192, 1000));
		// shoulders swapped, then zero shoulder vector
		send_frame(make_frame(700, 5300, 8000, -700, 5350, 8050, 700, 1000, -700, 1000));
		send_frame(make_frame(0, 5300, 8000, 0, 5300, 8000, 0, 1000, 0, 1000));
		// widest posed frame, repeated until the width saturates
		repeat (7)
			send_frame(make_frame(-32768, 32767, 0, 32767, -32767, 0,
				-32768, -32768, 32767, -32768));
		s_axis_tvalid <= 1'b0;

		for (int p = 0; p < NUM_PHASES; p++) begin
			// registers change only with the block idle
			while (sb.pending() != 0) @(posedge clk);
			src_idle_pct  = (p < 2) ? 32 : (p < 4) ? 69 : 0;
			sink_idle_pct = (p < 2) ? 69 : (p < 4) ? 32 : 0;
			case (p)
				0: apply_setting(PLANE_A_RST, PLANE_B_RST, PLANE_C_RST, PLANE_D_RST,
					16'h8800, YAW_LIM_RST);
				1: apply_setting(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
				2: apply_setting(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
				3: apply_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'h0001, 16'h0001);
				4: apply_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom_range(256, 8192)), 16'($urandom_range(2000, 40000)));
				default: apply_setting(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom));
			endcase
			for (int n = 0; n < phase_len[p]; n++) send_frame(random_frame());
			s_axis_tvalid <= 1'b0;
		end

		// drain, then leave room for any stray result
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== skeleton_pose_and_measure.f =====
hdl/sapm_pkg.sv
hdl/skeleton_pose_and_measure.sv
tb/sv/tb_skeleton_pose_and_measure.sv
